### hdl/uits_pkg.sv
// Package for the unwind index table search block.
// Holds the beat structs, the operation and register codes and the control structs.
// No dependencies.
package uits_pkg;

    // Operation codes of an input beat
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam logic CFG_TABLE_BASE  = 1'b0;
    localparam logic CFG_ENTRY_COUNT = 1'b1;

    localparam int CFG_DATA_W  = 32;
    localparam int ENTRY_CNT_W = 11;
    localparam int LOAD_IDX_W  = 10;
    localparam int OFFSET_W    = 31;

    typedef struct packed {
        logic        operation;
        logic [9:0]  load_index;
        logic [30:0] offset_word;
        logic [31:0] query_address;
    } t_in_beat;

    typedef struct packed {
        logic        found;
        logic [9:0]  match_index;
        logic [31:0] match_address;
        logic [31:0] function_base;
    } t_out_beat;

    // Entry load request toward the base store
    typedef struct packed {
        logic        en;
        logic [9:0]  index;
        logic [30:0] offset;
    } t_load_req;

    // Lookup start toward the search sequencer
    typedef struct packed {
        logic        start;
        logic [31:0] query;
    } t_search_req;

    // Search result back to the top level
    typedef struct packed {
        logic      done;
        t_out_beat beat;
    } t_search_rsp;

endpackage

### hdl/unwind_index_table_search.sv
// Unwind index table search, top level: handshakes, configuration and result register.
// Instantiates uits_base_store and uits_search_ctrl. Depends on uits_pkg.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_in_beat  (t_in_beat)
//  out      | output    | o_out_valid / i_out_stall  | o_out_beat (t_out_beat)
//  cfg      | input     | i_cfg_we, no wait          | i_cfg_index, i_cfg_data
//
// A load beat writes the base store at accept, through the decode adder.
// A lookup beat passes S_START, k probes in S_PROBE and then S_RESULT on its way to the
// result register (k at most floor(log2(n)) + 1 for n entries); the single read port of the
// base store and the compare behind it give one probe per cycle.
// Reset clears control state, the cfg registers and the output valid; store and data regs are not cleared.
// The next beat is taken once the result sits in the output register, so a stalled
// result holds there while the following beat is already at work.
module unwind_index_table_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  uits_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output uits_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import uits_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [31:0]            r_table_base;
    logic [ENTRY_CNT_W-1:0] r_entry_count;
    logic                   r_out_valid;
    t_out_beat              r_out_beat;

    logic          in_acc;
    logic          busy;
    logic          res_ready;
    logic [CW-1:0] count_clamped;
    logic [31:0]   count_ext;
    t_load_req     load;
    t_search_req   req;
    t_search_rsp   rsp;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // input accept and request decode
    always_comb begin
        in_acc        = i_in_valid && !busy;
        load.en       = in_acc && (i_in_beat.operation == OP_LOAD);
        load.index    = i_in_beat.load_index;
        load.offset   = i_in_beat.offset_word;
        req.start     = in_acc && (i_in_beat.operation == OP_LOOKUP);
        req.query     = i_in_beat.query_address;
        count_ext     = {21'd0, r_entry_count};
        count_clamped = (count_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                       : count_ext[CW-1:0];
        res_ready     = !r_out_valid || !i_out_stall;
    end

    assign o_in_stall = busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_base  <= '0;
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TABLE_BASE:  r_table_base  <= i_cfg_data;
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[ENTRY_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp.done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (rsp.done && res_ready) begin
            r_out_beat <= rsp.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    uits_base_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW         (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_load      (load),
        .i_table_base(r_table_base),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data)
    );

    uits_search_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_count     (count_clamped),
        .i_table_base(r_table_base),
        .i_rd_data   (rd_data),
        .i_res_ready (res_ready),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_rsp       (rsp),
        .o_busy      (busy)
    );

endmodule

### hdl/uits_base_store.sv
// Base store: decodes place-relative offsets and holds the function bases.
// Single write port, one registered read port. Depends on uits_pkg.
module uits_base_store #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10
) (
    input  logic                i_clk,
    input  uits_pkg::t_load_req i_load,
    input  logic [31:0]         i_table_base,
    input  logic                i_rd_en,
    input  logic [IW-1:0]       i_rd_addr,
    output logic [31:0]         o_rd_data
);
    import uits_pkg::*;

    logic [31:0] r_mem [TABLE_DEPTH];
    logic [31:0] r_rd_data;

    logic [31:0] idx_ext;
    logic [31:0] entry_addr;
    logic [31:0] off_sext;
    logic [31:0] dec_base;
    logic        wr_en;

    // entry address plus sign-extended offset, modulo 2^32
    always_comb begin
        idx_ext    = {22'd0, i_load.index};
        entry_addr = i_table_base + (idx_ext << 3);
        off_sext   = {i_load.offset[OFFSET_W-1], i_load.offset};
        dec_base   = entry_addr + off_sext;
        wr_en      = i_load.en && (idx_ext < 32'(TABLE_DEPTH));
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx_ext[IW-1:0]] <= dec_base;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/uits_search_ctrl.sv
// Binary search sequencer: one compare per cycle against the store's read data.
// Drives the store's read port and builds the result beat. Depends on uits_pkg.
module uits_search_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10,
    parameter int CW          = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uits_pkg::t_search_req i_req,
    input  logic [CW-1:0]         i_count,
    input  logic [31:0]           i_table_base,
    input  logic [31:0]           i_rd_data,
    input  logic                  i_res_ready,
    output logic                  o_rd_en,
    output logic [IW-1:0]         o_rd_addr,
    output uits_pkg::t_search_rsp o_rsp,
    output logic                  o_busy
);
    import uits_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_RESULT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [31:0]   r_q, n_q;
    logic [31:0]   r_best, n_best;

    logic          probe_lt;
    logic [CW-1:0] c_lo, c_hi, c_mid;
    logic          c_more;
    logic [31:0]   idx_ext;
    logic          found;

    // narrow the window with the compare result, then pick the next probe
    always_comb begin
        probe_lt = r_q < i_rd_data;
        c_lo     = r_lo;
        c_hi     = r_hi;
        if (r_state == S_PROBE) begin
            if (probe_lt) begin
                c_hi = r_mid;
            end else begin
                c_lo = r_mid + CW'(1);
            end
        end
        c_mid     = c_lo + ((c_hi - c_lo) >> 1);
        c_more    = c_lo < c_hi;
        o_rd_en   = ((r_state == S_START) || (r_state == S_PROBE)) && c_more;
        o_rd_addr = c_mid[IW-1:0];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_q     = r_q;
        n_best  = r_best;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_lo    = '0;
                    n_hi    = i_count;
                    n_q     = i_req.query;
                    n_state = S_START;
                end
            end
            S_START, S_PROBE: begin
                n_lo  = c_lo;
                n_hi  = c_hi;
                n_mid = c_mid;
                // lo moved past the probe: that entry is the best so far
                if ((r_state == S_PROBE) && !probe_lt) begin
                    n_best = i_rd_data;
                end
                n_state = c_more ? S_PROBE : S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_q    <= n_q;
        r_best <= n_best;
    end

    // result beat: entry lo-1, or all zero when lo never moved
    always_comb begin
        found   = r_lo != '0;
        idx_ext = 32'(r_lo) - 32'd1;
        o_rsp.done = r_state == S_RESULT;
        if (found) begin
            o_rsp.beat.found         = 1'b1;
            o_rsp.beat.match_index   = idx_ext[LOAD_IDX_W-1:0];
            o_rsp.beat.match_address = i_table_base + (idx_ext << 3);
            o_rsp.beat.function_base = r_best;
        end else begin
            o_rsp.beat = '0;
        end
        o_busy = r_state != S_IDLE;
    end

    // window never inverts while probing
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo < r_hi))
        else $error("search window inverted");

    // window only shrinks from probe to probe
    a_window_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && n_state == S_PROBE) |=>
        (r_lo >= $past(r_lo) && r_hi <= $past(r_hi) && r_hi - r_lo < $past(r_hi - r_lo)))
        else $error("search window did not shrink");

    // window stays inside the table
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_RESULT) |-> (32'(r_hi) <= 32'(TABLE_DEPTH)))
        else $error("search window beyond table depth");

    // a not-found result carries zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.done && !o_rsp.beat.found) |->
        (o_rsp.beat.match_address == 32'd0 && o_rsp.beat.function_base == 32'd0))
        else $error("not-found result with nonzero fields");

endmodule
